// ----- rtl/core/bsa_pkg.sv -----
// bsa_pkg: shared types, codes and constants of the banker safety allocator.
// Used by bsa_ctrl, bsa_datapath and banker_safety_allocator. No dependencies.
`timescale 1ns / 1ps
package bsa_pkg;

	localparam int NUM_PROCS_DEF   = 5;
	localparam int COUNT_WIDTH_DEF = 8;
	localparam int NUM_RES         = 3;
	localparam int OP_W            = 3;
	localparam int PROC_W          = 3;
	localparam int AMOUNT_W        = 8;
	localparam int STATUS_W        = 3;
	localparam int ORDER_SLOTS     = 5;
	localparam int ORDER_W         = ORDER_SLOTS * PROC_W;
	localparam int OCOUNT_W        = 3;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD_ALLOC = 3'd0,
		OP_LOAD_NEED  = 3'd1,
		OP_LOAD_AVAIL = 3'd2,
		OP_REQUEST    = 3'd3,
		OP_CHECK      = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 3'd0,
		ST_EXC_NEED   = 3'd1,
		ST_EXC_AVAIL  = 3'd2,
		ST_UNSAFE     = 3'd3,
		ST_LOADED     = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_REQ_TEST,
		S_SCAN,
		S_FINISH,
		S_RESP
	} state_t;

	typedef struct packed {
		logic    latch;
		logic    load_row;
		logic    load_avail;
		logic    grant;
		logic    scan_init;
		logic    scan_step;
		logic    rollback;
		logic    status_we;
		status_t status_code;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic proc_ok;
		logic exceeds_need;
		logic exceeds_avail;
		logic scan_done;
		logic safe;
	} sts_t;

endpackage

// ----- rtl/core/bsa_ctrl.sv -----
// bsa_ctrl: sequencing state machine of the banker safety allocator.
// Depends on bsa_pkg; drives bsa_datapath through cmd_t, reads sts_t.
`timescale 1ns / 1ps
module bsa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	output logic           done,
	input  bsa_pkg::sts_t  sts,
	output bsa_pkg::cmd_t  cmd
);

	bsa_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsa_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.status_code = bsa_pkg::ST_LOADED;
		case (state_q)
			bsa_pkg::S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d = bsa_pkg::S_EXEC;
				end
			end
			bsa_pkg::S_EXEC: begin
				case (sts.op)
					bsa_pkg::OP_LOAD_ALLOC, bsa_pkg::OP_LOAD_NEED: begin
						cmd.load_row = sts.proc_ok;
						cmd.status_we = 1'b1;
						state_d = bsa_pkg::S_RESP;
					end
					bsa_pkg::OP_LOAD_AVAIL: begin
						cmd.load_avail = 1'b1;
						cmd.status_we = 1'b1;
						state_d = bsa_pkg::S_RESP;
					end
					bsa_pkg::OP_REQUEST: begin
						state_d = bsa_pkg::S_REQ_TEST;
					end
					bsa_pkg::OP_CHECK: begin
						cmd.scan_init = 1'b1;
						state_d = bsa_pkg::S_SCAN;
					end
					default: begin
						cmd.status_we = 1'b1;
						state_d = bsa_pkg::S_RESP;
					end
				endcase
			end
			bsa_pkg::S_REQ_TEST: begin
				if (!sts.proc_ok || sts.exceeds_need) begin
					cmd.status_we = 1'b1;
					cmd.status_code = bsa_pkg::ST_EXC_NEED;
					state_d = bsa_pkg::S_RESP;
				end else if (sts.exceeds_avail) begin
					cmd.status_we = 1'b1;
					cmd.status_code = bsa_pkg::ST_EXC_AVAIL;
					state_d = bsa_pkg::S_RESP;
				end else begin
					cmd.grant = 1'b1;
					cmd.scan_init = 1'b1;
					state_d = bsa_pkg::S_SCAN;
				end
			end
			bsa_pkg::S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done) begin
					state_d = bsa_pkg::S_FINISH;
				end
			end
			bsa_pkg::S_FINISH: begin
				cmd.status_we = 1'b1;
				if (sts.safe) begin
					cmd.status_code = bsa_pkg::ST_OK;
				end else begin
					cmd.status_code = bsa_pkg::ST_UNSAFE;
					cmd.rollback = (sts.op == bsa_pkg::OP_REQUEST);
				end
				state_d = bsa_pkg::S_RESP;
			end
			bsa_pkg::S_RESP: begin
				state_d = bsa_pkg::S_IDLE;
			end
			default: begin
				state_d = bsa_pkg::S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != bsa_pkg::S_IDLE);
	assign done = (state_q == bsa_pkg::S_RESP);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("result strobe longer than one cycle");

	a_rollback_req: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rollback |-> sts.op == bsa_pkg::OP_REQUEST && !sts.safe)
		else $error("rollback outside an unsafe request");

	a_grant_checked: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.grant |-> sts.proc_ok && !sts.exceeds_need && !sts.exceeds_avail)
		else $error("grant without passing request checks");

endmodule

// ----- rtl/core/bsa_datapath.sv -----
// bsa_datapath: allocation/need tables, available vector, request checks and
// the safety scan registers. Depends on bsa_pkg; commanded by bsa_ctrl.
`timescale 1ns / 1ps
module bsa_datapath #(
	parameter int NUM_PROCS   = bsa_pkg::NUM_PROCS_DEF,
	parameter int COUNT_WIDTH = bsa_pkg::COUNT_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [bsa_pkg::OP_W-1:0]          operation,
	input  logic [bsa_pkg::PROC_W-1:0]        process,
	input  logic [bsa_pkg::AMOUNT_W-1:0]      amount_0,
	input  logic [bsa_pkg::AMOUNT_W-1:0]      amount_1,
	input  logic [bsa_pkg::AMOUNT_W-1:0]      amount_2,
	input  bsa_pkg::cmd_t                     cmd,
	output bsa_pkg::sts_t                     sts,
	output logic [bsa_pkg::STATUS_W-1:0]      status,
	output logic                              safe,
	output logic [bsa_pkg::ORDER_W-1:0]       safe_order,
	output logic [bsa_pkg::OCOUNT_W-1:0]      order_count
);

	localparam int IW  = $clog2(NUM_PROCS);
	localparam int PCW = $clog2(NUM_PROCS + 1);
	localparam int NR  = bsa_pkg::NUM_RES;

	typedef logic [COUNT_WIDTH-1:0] cnt_t;

	cnt_t alloc_q [NUM_PROCS][NR];
	cnt_t need_q  [NUM_PROCS][NR];
	cnt_t avail_q [NR];
	cnt_t work_q  [NR];
	cnt_t amt_q   [NR];
	cnt_t sv_alloc_q [NR];
	cnt_t sv_need_q  [NR];
	cnt_t sv_avail_q [NR];

	bsa_pkg::op_t                 op_q;
	logic [bsa_pkg::PROC_W-1:0]   proc_q;
	logic [NUM_PROCS-1:0]         fin_q;
	logic [IW-1:0]                ptr_q;
	logic [PCW-1:0]               placed_q;
	logic [bsa_pkg::ORDER_W-1:0]  order_q;
	bsa_pkg::status_t             status_q;

	logic          proc_ok;
	logic [IW-1:0] proc_idx;
	logic [IW-1:0] rd_idx;
	cnt_t          need_rd [NR];
	cnt_t          alloc_rd [NR];
	cnt_t          grant_alloc [NR];
	cnt_t          work_sum [NR];
	logic          fits;
	logic          take;
	logic          last_place;
	logic          exc_need;
	logic          exc_avail;

	function automatic cnt_t sat_add(input cnt_t a, input cnt_t b);
		logic [COUNT_WIDTH:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : s[COUNT_WIDTH-1:0];
	endfunction

	assign proc_ok  = ({1'b0, proc_q} < (bsa_pkg::PROC_W + 1)'(NUM_PROCS));
	assign proc_idx = proc_ok ? proc_q[IW-1:0] : '0;
	assign rd_idx   = cmd.scan_step ? ptr_q : proc_idx;

	always_comb begin
		fits = !fin_q[rd_idx];
		exc_need = 1'b0;
		exc_avail = 1'b0;
		for (int j = 0; j < NR; j++) begin
			need_rd[j]     = need_q[rd_idx][j];
			alloc_rd[j]    = alloc_q[rd_idx][j];
			grant_alloc[j] = sat_add(alloc_rd[j], amt_q[j]);
			work_sum[j]    = sat_add(work_q[j], alloc_rd[j]);
			if (need_rd[j] > work_q[j]) fits = 1'b0;
			if (amt_q[j] > need_rd[j]) exc_need = 1'b1;
			if (amt_q[j] > avail_q[j]) exc_avail = 1'b1;
		end
	end

	assign take       = cmd.scan_step && fits;
	assign last_place = (placed_q == PCW'(NUM_PROCS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_PROCS; p++) begin
				for (int j = 0; j < NR; j++) begin
					alloc_q[p][j] <= '0;
					need_q[p][j]  <= '0;
				end
			end
			for (int j = 0; j < NR; j++) begin
				avail_q[j] <= '0;
			end
			fin_q    <= '0;
			ptr_q    <= '0;
			placed_q <= '0;
			order_q  <= '0;
			status_q <= bsa_pkg::ST_LOADED;
		end else begin
			if (cmd.latch) begin
				placed_q <= '0;
				order_q  <= '0;
			end
			if (cmd.load_row) begin
				for (int j = 0; j < NR; j++) begin
					if (op_q == bsa_pkg::OP_LOAD_ALLOC) alloc_q[proc_idx][j] <= amt_q[j];
					else need_q[proc_idx][j] <= amt_q[j];
				end
			end
			if (cmd.load_avail) begin
				for (int j = 0; j < NR; j++) avail_q[j] <= amt_q[j];
			end
			if (cmd.grant) begin
				for (int j = 0; j < NR; j++) begin
					avail_q[j]           <= avail_q[j] - amt_q[j];
					alloc_q[proc_idx][j] <= grant_alloc[j];
					need_q[proc_idx][j]  <= need_rd[j] - amt_q[j];
				end
			end
			if (cmd.rollback) begin
				for (int j = 0; j < NR; j++) begin
					avail_q[j]           <= sv_avail_q[j];
					alloc_q[proc_idx][j] <= sv_alloc_q[j];
					need_q[proc_idx][j]  <= sv_need_q[j];
				end
			end
			if (cmd.scan_init) begin
				fin_q    <= '0;
				ptr_q    <= '0;
				placed_q <= '0;
				order_q  <= '0;
			end
			if (cmd.scan_step) begin
				if (fits) begin
					fin_q[ptr_q] <= 1'b1;
					placed_q     <= placed_q + PCW'(1);
					ptr_q        <= '0;
					for (int k = 0; k < bsa_pkg::ORDER_SLOTS; k++) begin
						if (32'(placed_q) == k)
							order_q[k*bsa_pkg::PROC_W +: bsa_pkg::PROC_W]
								<= bsa_pkg::PROC_W'(ptr_q);
					end
				end else begin
					ptr_q <= ptr_q + IW'(1);
				end
			end
			if (cmd.status_we) status_q <= cmd.status_code;
		end
	end

	// item payload, rollback snapshot and work vector
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q     <= bsa_pkg::op_t'(operation);
			proc_q   <= process;
			amt_q[0] <= COUNT_WIDTH'(amount_0);
			amt_q[1] <= COUNT_WIDTH'(amount_1);
			amt_q[2] <= COUNT_WIDTH'(amount_2);
		end
		if (cmd.grant) begin
			for (int j = 0; j < NR; j++) begin
				sv_avail_q[j] <= avail_q[j];
				sv_alloc_q[j] <= alloc_rd[j];
				sv_need_q[j]  <= need_rd[j];
			end
		end
		if (cmd.scan_init) begin
			for (int j = 0; j < NR; j++) begin
				work_q[j] <= cmd.grant ? avail_q[j] - amt_q[j] : avail_q[j];
			end
		end else if (take) begin
			for (int j = 0; j < NR; j++) work_q[j] <= work_sum[j];
		end
	end

	always_comb begin
		sts = '0;
		sts.op            = op_q;
		sts.proc_ok       = proc_ok;
		sts.exceeds_need  = exc_need;
		sts.exceeds_avail = exc_avail;
		sts.scan_done     = fits ? last_place : (ptr_q == IW'(NUM_PROCS - 1));
		sts.safe          = (placed_q == PCW'(NUM_PROCS));
	end

	assign status      = status_q;
	assign safe        = (placed_q == PCW'(NUM_PROCS));
	assign safe_order  = order_q;
	assign order_count = (32'(placed_q) > 32'd7) ? bsa_pkg::OCOUNT_W'(7)
		: bsa_pkg::OCOUNT_W'(placed_q);

endmodule

// ----- rtl/core/banker_safety_allocator.sv -----
// banker_safety_allocator: a load steps S_EXEC, S_RESP; a rejected request S_EXEC,
// S_REQ_TEST, S_RESP. A check steps S_EXEC, S_SCAN, S_FINISH, S_RESP; a granted request
// steps S_REQ_TEST between S_EXEC and S_SCAN. The scan reads one process row per cycle.
// One item at a time: busy from accept through done, next accept after busy falls.
// Results stay registered; done is high for a single cycle; the receiver cannot stall.
// arst_n clears the tables, the available vector and the controller.
`timescale 1ns / 1ps
module banker_safety_allocator #(
	parameter int NUM_PROCS   = bsa_pkg::NUM_PROCS_DEF,
	parameter int COUNT_WIDTH = bsa_pkg::COUNT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [bsa_pkg::OP_W-1:0]      operation,
	input  logic [bsa_pkg::PROC_W-1:0]    process,
	input  logic [bsa_pkg::AMOUNT_W-1:0]  amount_0,
	input  logic [bsa_pkg::AMOUNT_W-1:0]  amount_1,
	input  logic [bsa_pkg::AMOUNT_W-1:0]  amount_2,
	output logic                          done,
	output logic [bsa_pkg::STATUS_W-1:0]  status,
	output logic                          safe,
	output logic [bsa_pkg::ORDER_W-1:0]   safe_order,
	output logic [bsa_pkg::OCOUNT_W-1:0]  order_count
);

	bsa_pkg::cmd_t cmd;
	bsa_pkg::sts_t sts;

	bsa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.sts    (sts),
		.cmd    (cmd)
	);

	bsa_datapath #(
		.NUM_PROCS   (NUM_PROCS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.operation   (operation),
		.process     (process),
		.amount_0    (amount_0),
		.amount_1    (amount_1),
		.amount_2    (amount_2),
		.cmd         (cmd),
		.sts         (sts),
		.status      (status),
		.safe        (safe),
		.safe_order  (safe_order),
		.order_count (order_count)
	);

endmodule
